@@ hdl/bwd_pkg.sv @@
// Shared types, register codes and the minterm function of the blitter word datapath.
package bwd_pkg;

  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MINTERM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_SHIFT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_SHIFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_CARRY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MASK = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_MASK  = 3'd7;

  // Fill mode codes; the fourth code behaves as inclusive fill
  localparam logic [1:0] FILL_OFF  = 2'd0;
  localparam logic [1:0] FILL_EXCL = 2'd1;
  localparam logic [1:0] FILL_INCL = 2'd2;

  localparam logic [WORD_W-1:0] MASK_RESET = 16'hFFFF;

  typedef struct packed {
    logic [WORD_W-1:0] raw_a;
    logic [WORD_W-1:0] raw_b;
    logic [WORD_W-1:0] raw_c;
    logic              row_first;
    logic              row_last;
    logic              blit_start;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] d_word;
    logic              d_row_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        minterm;
    logic [3:0]        a_shift;
    logic [3:0]        b_shift;
    logic              descending;
    logic [1:0]        fill_mode;
    logic              fill_carry_start;
    logic [WORD_W-1:0] first_mask;
    logic [WORD_W-1:0] last_mask;
  } cfg_t;

  // Bitwise truth table lookup: bit {a,b,c} of lut gives each output bit
  function automatic logic [WORD_W-1:0] minterm_eval(
    input logic [WORD_W-1:0] a,
    input logic [WORD_W-1:0] b,
    input logic [WORD_W-1:0] c,
    input logic [7:0]        lut
  );
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = lut[{a[i], b[i], c[i]}];
    end
    return r;
  endfunction

endpackage

@@ hdl/bwd_cfg_regs.sv @@
// Configuration register file of the blitter word datapath.
module bwd_cfg_regs
  import bwd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MINTERM:    cfg_d.minterm          = cfg_data_i[7:0];
        CFG_A_SHIFT:    cfg_d.a_shift          = cfg_data_i[3:0];
        CFG_B_SHIFT:    cfg_d.b_shift          = cfg_data_i[3:0];
        CFG_DESCENDING: cfg_d.descending       = cfg_data_i[0];
        CFG_FILL_MODE:  cfg_d.fill_mode        = cfg_data_i[1:0];
        CFG_FILL_CARRY: cfg_d.fill_carry_start = cfg_data_i[0];
        CFG_FIRST_MASK: cfg_d.first_mask       = cfg_data_i;
        CFG_LAST_MASK:  cfg_d.last_mask        = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                  <= '0;
      cfg_q.first_mask       <= MASK_RESET;
      cfg_q.last_mask        <= MASK_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/bwd_shift.sv @@
// Funnel shifter that joins the current word with the word held from before.
module bwd_shift
  import bwd_pkg::*;
(
  input  logic [WORD_W-1:0] cur_i,
  input  logic [WORD_W-1:0] held_i,
  input  logic [3:0]        count_i,
  input  logic              left_i,
  output logic [WORD_W-1:0] word_o
);

  logic [2*WORD_W-1:0] right_pair;
  logic [2*WORD_W-1:0] left_pair;

  // Right: held word supplies upper bits; left: held word supplies lower bits
  assign right_pair = {held_i, cur_i} >> count_i;
  assign left_pair  = {cur_i, held_i} << count_i;

  assign word_o = left_i ? left_pair[2*WORD_W-1:WORD_W] : right_pair[WORD_W-1:0];

endmodule

@@ hdl/bwd_fill.sv @@
// Area fill unit: inclusive or exclusive fill across one word, either direction.
module bwd_fill
  import bwd_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  input  logic              carry_i,
  input  logic [1:0]        mode_i,
  input  logic              descending_i,
  output logic [WORD_W-1:0] word_o,
  output logic              carry_o
);

  logic [WORD_W-1:0] ord;
  logic [WORD_W-1:0] filled;
  logic [WORD_W-1:0] res;
  logic [WORD_W-1:0] below;
  logic              pre;
  logic              fill_en;
  logic              inclusive;

  assign fill_en   = (mode_i != FILL_OFF);
  // Codes with the high bit set fill inclusively
  assign inclusive = mode_i[1];

  // Put bits in fill order: bit 0 first ascending, bit 15 first descending
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      ord[i] = descending_i ? word_i[WORD_W-1-i] : word_i[i];
    end
  end

  // Carry into each position is a prefix parity of the bits ahead of it
  always_comb begin
    filled = '0;
    below  = '0;
    pre    = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      below     = WORD_W'((32'd1 << i) - 32'd1);
      pre       = carry_i ^ (^(ord & below));
      filled[i] = inclusive ? (ord[i] | pre) : (ord[i] ^ pre);
    end
  end

  // Back to word order
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      res[i] = descending_i ? filled[WORD_W-1-i] : filled[i];
    end
  end

  assign word_o  = fill_en ? res : word_i;
  assign carry_o = fill_en ? (carry_i ^ (^word_i)) : carry_i;

endmodule

@@ hdl/blitter_word_datapath.sv @@
// Top level of the blitter word datapath: input register, word logic, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i), while not stalled, takes
//   one word transaction per cycle with its row and blit marks. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns one D word per input word,
//   in order. Configuration writes arrive on cfg_valid_i / cfg_ready_o with a
//   register index and data; ready is always high. Write them only while idle.
//   A word accepted into the input register moves into the result register
//   when that register is free. Throughput: one word per cycle while the
//   output is not stalled, set by the single pass from the input register
//   through shift, minterm and fill to the result register; the held A/B
//   words and fill carry update as a word moves into the result register.
//   Reset clears both pipeline valids, the held words, the fill carry and
//   the configuration (masks to all ones).
//   When the receiver stalls, the result register holds its word; one more
//   word may sit in the input register, after which in_stall_o rises.
module blitter_word_datapath
  import bwd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  cfg_t              cfg;
  logic              s1_valid_q, s1_valid_d;
  in_item_t          s1_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;
  logic [WORD_W-1:0] a_prev_q, b_prev_q;
  logic              carry_q;

  logic              out_free;
  logic              advance;
  logic              in_accept;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] a_masked;
  logic [WORD_W-1:0] a_held, b_held;
  logic [WORD_W-1:0] a_shifted, b_shifted;
  logic [WORD_W-1:0] logic_word;
  logic [WORD_W-1:0] d_word;
  logic              carry_in, carry_next;

  bwd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline flow control
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  // Edge masks on A
  always_comb begin
    mask = MASK_RESET;
    if (s1_q.row_first) mask = mask & cfg.first_mask;
    if (s1_q.row_last)  mask = mask & cfg.last_mask;
  end
  assign a_masked = s1_q.raw_a & mask;

  // Blit start drops the held words
  assign a_held = s1_q.blit_start ? '0 : a_prev_q;
  assign b_held = s1_q.blit_start ? '0 : b_prev_q;

  bwd_shift u_shift_a (
    .cur_i   (a_masked),
    .held_i  (a_held),
    .count_i (cfg.a_shift),
    .left_i  (cfg.descending),
    .word_o  (a_shifted)
  );

  bwd_shift u_shift_b (
    .cur_i   (s1_q.raw_b),
    .held_i  (b_held),
    .count_i (cfg.b_shift),
    .left_i  (cfg.descending),
    .word_o  (b_shifted)
  );

  assign logic_word = minterm_eval(a_shifted, b_shifted, s1_q.raw_c, cfg.minterm);

  // Row start reloads the fill carry
  assign carry_in = s1_q.row_first ? cfg.fill_carry_start : carry_q;

  bwd_fill u_fill (
    .word_i       (logic_word),
    .carry_i      (carry_in),
    .mode_i       (cfg.fill_mode),
    .descending_i (cfg.descending),
    .word_o       (d_word),
    .carry_o      (carry_next)
  );

  // Control and word state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      a_prev_q    <= '0;
      b_prev_q    <= '0;
      carry_q     <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        a_prev_q <= a_masked;
        b_prev_q <= s1_q.raw_b;
        carry_q  <= carry_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
    if (advance) begin
      out_q.d_word     <= d_word;
      out_q.d_row_last <= s1_q.row_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/bwd_checker.sv @@
// Port-level assertions for the blitter word datapath, bound to the top level.
module bwd_checker
  import bwd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input out_item_t            out_data_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Input backpressure only arises from a stalled, full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Accepted input words pass both registers to a valid output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted word did not reach the output");

  // The config port never blocks a write
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind blitter_word_datapath bwd_checker u_bwd_checker (.*);
